// ----- rtl/core/first_fit_free_list_allocator_top_assert.svh -----
// Assertion macros for the allocator. Clock clk, reset arst_n.
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication
`define FFA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ffa assertion failed");

// next-cycle implication
`define FFA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ffa assertion failed");

`endif

// ----- rtl/core/ffa_pkg.sv -----
package ffa_pkg;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	localparam logic CFG_HEAP_BASE  = 1'b0;
	localparam logic CFG_HEAP_LIMIT = 1'b1;

	// largest request that still rounds up within 32 bits
	localparam logic [31:0] MAX_REQUEST = 32'hFFFF_FFF8;

	typedef enum logic [2:0] {
		STAT_REUSED  = 3'd0,
		STAT_GROWN   = 3'd1,
		STAT_NOMEM   = 3'd2,
		STAT_DROPPED = 3'd3,
		STAT_FREED   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SHIFT,
		ST_GROW
	} state_t;

	typedef struct packed {
		logic [31:0] addr;
		logic [31:0] size;
	} entry_t;

	typedef struct packed {
		logic [31:0] addr;
		logic [31:0] size;
		status_t     status;
	} result_t;

	typedef struct packed {
		logic        ld;
		logic [31:0] base;
	} brk_load_t;

endpackage

// ----- rtl/core/ffa_core.sv -----
module ffa_core #(
	parameter int FREE_SLOTS   = 16,
	parameter int HEADER_BYTES = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               kind,
	input  logic [31:0]        request_size,
	input  logic [31:0]        block_address,
	input  logic [31:0]        block_size,
	input  ffa_pkg::brk_load_t brk_load,
	input  logic [31:0]        heap_limit,
	output logic               res_valid,
	output ffa_pkg::result_t   res,
	input  logic               res_take
);

	localparam int IDX_W = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
	localparam int CNT_W = $clog2(FREE_SLOTS + 1);

	// free table, one entry per slot, oldest at slot 0
	ffa_pkg::entry_t mem [FREE_SLOTS];
	ffa_pkg::entry_t rdata_s1;
	logic            mem_we;
	logic            mem_re;
	logic [IDX_W-1:0] mem_waddr;
	logic [IDX_W-1:0] mem_raddr;
	ffa_pkg::entry_t mem_wdata;

	ffa_pkg::state_t  state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [31:0]      brk_q, brk_d;
	logic [31:0]      rnd_q, rnd_d;
	logic [IDX_W-1:0] ptr_q, ptr_d;
	logic             more_q, more_d;
	logic [CNT_W-1:0] sh_rd_q, sh_rd_d;
	logic [IDX_W-1:0] sh_wr_q, sh_wr_d;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_slot_s1;
	logic             res_vld_q;
	ffa_pkg::result_t res_q, res_d;
	logic             res_set;

	logic        accept;
	logic        req_ovf;
	logic [31:0] rnd;
	logic        hit;
	logic [33:0] end_sum;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (mem_re)
			rdata_s1 <= mem[mem_raddr];
	end

	assign in_stall = (state_q != ffa_pkg::ST_IDLE) || res_vld_q;
	assign accept   = in_valid && !in_stall;
	assign req_ovf  = request_size > ffa_pkg::MAX_REQUEST;
	assign rnd      = {request_size[31:3] + 29'(|request_size[2:0]), 3'b000};
	assign hit      = rd_vld_s1 && (rdata_s1.size >= rnd_q);
	assign end_sum  = {2'b00, brk_q} + {2'b00, rnd_q} + 34'(HEADER_BYTES);

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		brk_d     = brk_q;
		rnd_d     = rnd_q;
		ptr_d     = ptr_q;
		more_d    = more_q;
		sh_rd_d   = sh_rd_q;
		sh_wr_d   = sh_wr_q;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = sh_wr_q;
		mem_raddr = ptr_q;
		mem_wdata = rdata_s1;
		res_set   = 1'b0;
		res_d     = '{addr: 32'd0, size: 32'd0, status: ffa_pkg::STAT_FREED};

		unique case (state_q)
			ffa_pkg::ST_IDLE: begin
				if (accept) begin
					if (kind == ffa_pkg::KIND_FREE) begin
						res_set = 1'b1;
						if (block_address == 32'd0) begin
							res_d.status = ffa_pkg::STAT_FREED;
						end else if (cnt_q == CNT_W'(FREE_SLOTS)) begin
							res_d.status = ffa_pkg::STAT_DROPPED;
						end else begin
							mem_we         = 1'b1;
							mem_waddr      = cnt_q[IDX_W-1:0];
							mem_wdata.addr = block_address;
							mem_wdata.size = {block_size[31:3], 3'b000};
							cnt_d          = cnt_q + CNT_W'(1);
							res_d.status   = ffa_pkg::STAT_FREED;
						end
					end else if (req_ovf) begin
						res_set      = 1'b1;
						res_d.status = ffa_pkg::STAT_NOMEM;
					end else begin
						rnd_d = rnd;
						if (cnt_q == '0) begin
							state_d = ffa_pkg::ST_GROW;
						end else begin
							state_d = ffa_pkg::ST_SEARCH;
							ptr_d   = IDX_W'(cnt_q - CNT_W'(1));
							more_d  = 1'b1;
						end
					end
				end
			end
			ffa_pkg::ST_SEARCH: begin
				// newest first: read one slot a cycle, test the one read last cycle
				if (hit) begin
					res_set      = 1'b1;
					res_d.addr   = rdata_s1.addr;
					res_d.size   = rdata_s1.size;
					res_d.status = ffa_pkg::STAT_REUSED;
					sh_rd_d      = CNT_W'(rd_slot_s1) + CNT_W'(1);
					sh_wr_d      = rd_slot_s1;
					state_d      = ffa_pkg::ST_SHIFT;
				end else if (more_q) begin
					mem_re    = 1'b1;
					mem_raddr = ptr_q;
					if (ptr_q == '0)
						more_d = 1'b0;
					else
						ptr_d = ptr_q - IDX_W'(1);
				end else begin
					state_d = ffa_pkg::ST_GROW;
				end
			end
			ffa_pkg::ST_SHIFT: begin
				// close the gap: slot k+1 read, written back to k next cycle
				if (rd_vld_s1) begin
					mem_we    = 1'b1;
					mem_waddr = sh_wr_q;
					mem_wdata = rdata_s1;
					sh_wr_d   = sh_wr_q + IDX_W'(1);
				end
				if (sh_rd_q < cnt_q) begin
					mem_re    = 1'b1;
					mem_raddr = sh_rd_q[IDX_W-1:0];
					sh_rd_d   = sh_rd_q + CNT_W'(1);
				end else begin
					cnt_d   = cnt_q - CNT_W'(1);
					state_d = ffa_pkg::ST_IDLE;
				end
			end
			ffa_pkg::ST_GROW: begin
				res_set = 1'b1;
				state_d = ffa_pkg::ST_IDLE;
				if (end_sum > {2'b00, heap_limit}) begin
					res_d.status = ffa_pkg::STAT_NOMEM;
				end else begin
					res_d.addr   = brk_q + 32'(HEADER_BYTES);
					res_d.size   = rnd_q;
					res_d.status = ffa_pkg::STAT_GROWN;
					brk_d        = end_sum[31:0];
				end
			end
			default: state_d = ffa_pkg::ST_IDLE;
		endcase

		if (brk_load.ld)
			brk_d = brk_load.base;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ffa_pkg::ST_IDLE;
			cnt_q     <= '0;
			brk_q     <= 32'd0;
			more_q    <= 1'b0;
			rd_vld_s1 <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			brk_q     <= brk_d;
			more_q    <= more_d;
			rd_vld_s1 <= mem_re;
			if (res_set)
				res_vld_q <= 1'b1;
			else if (res_take)
				res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		rnd_q   <= rnd_d;
		ptr_q   <= ptr_d;
		sh_rd_q <= sh_rd_d;
		sh_wr_q <= sh_wr_d;
		if (mem_re)
			rd_slot_s1 <= mem_raddr;
		if (res_set)
			res_q <= res_d;
	end

	assign res_valid = res_vld_q;
	assign res       = res_q;

	`include "first_fit_free_list_allocator_top_assert.svh"

	`FFA_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= CNT_W'(FREE_SLOTS))
	`FFA_ASSERT_IMP(a_no_res_overwrite, res_set, !res_vld_q)
	`FFA_ASSERT_IMP(a_shift_order, (state_q == ffa_pkg::ST_SHIFT) && rd_vld_s1, CNT_W'(sh_wr_q) < sh_rd_q)
	`FFA_ASSERT_NXT(a_shift_pop, (state_q == ffa_pkg::ST_SHIFT) && (state_d == ffa_pkg::ST_IDLE), cnt_q == $past(cnt_q) - CNT_W'(1))
	`FFA_ASSERT_IMP(a_search_nonempty, (state_q == ffa_pkg::ST_IDLE) && (state_d == ffa_pkg::ST_SEARCH), cnt_q != '0)

endmodule

// ----- rtl/core/first_fit_free_list_allocator_top.sv -----
// First-fit heap allocator. Allocate items search a free table of FREE_SLOTS entries, newest
// first, and take the first block big enough whole; otherwise the break pointer grows, bounded
// by heap_limit. Free items push onto the table; a free of the null address is acknowledged
// without a push, and one to a full table is dropped. The table sits in one simple dual-port
// memory with registered read data, and that port sets the timing: one item is worked at a
// time. A free item, a null free, a dropped free or an oversize request is settled on accept,
// and its result then moves into the output register. An allocate searches the table newest
// first, testing each entry after its read, and grows the break pointer on a miss or on an
// empty table. One that reuses an entry then closes up the entries above the slot taken, each
// moving down one slot, while the result moves on to the output register. Results pass
// through a core result register and an output register, so a finished item may wait on
// out_stall while the next is accepted. Writing heap_base reloads the break pointer; the user
// must write configuration only while idle, and the block itself does not enforce it.
module first_fit_free_list_allocator_top #(
	parameter int FREE_SLOTS   = 16,
	parameter int HEADER_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [31:0] request_size,
	input  logic [31:0] block_address,
	input  logic [31:0] block_size,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] granted_address,
	output logic [31:0] granted_size,
	output logic [2:0]  status,
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	logic [31:0]        limit_q;
	ffa_pkg::brk_load_t brk_load;
	logic               core_res_vld;
	ffa_pkg::result_t   core_res;
	logic               res_take;
	logic               out_vld_q;
	ffa_pkg::result_t   out_q;

	assign brk_load.ld   = cfg_wr_en && (cfg_index == ffa_pkg::CFG_HEAP_BASE);
	assign brk_load.base = cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= 32'd0;
		end else if (cfg_wr_en && (cfg_index == ffa_pkg::CFG_HEAP_LIMIT)) begin
			limit_q <= cfg_data;
		end
	end

	ffa_core #(
		.FREE_SLOTS   (FREE_SLOTS),
		.HEADER_BYTES (HEADER_BYTES)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.kind          (kind),
		.request_size  (request_size),
		.block_address (block_address),
		.block_size    (block_size),
		.brk_load      (brk_load),
		.heap_limit    (limit_q),
		.res_valid     (core_res_vld),
		.res           (core_res),
		.res_take      (res_take)
	);

	// output register loads when empty or being drained this cycle
	assign res_take = core_res_vld && (!out_vld_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_take) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take)
			out_q <= core_res;
	end

	assign out_valid       = out_vld_q;
	assign granted_address = out_q.addr;
	assign granted_size    = out_q.size;
	assign status          = out_q.status;

endmodule

// ----- bench/tb_first_fit_free_list_allocator_top.sv -----
`timescale 1ns / 100ps

module tb_first_fit_free_list_allocator_top;

	localparam int FREE_SLOTS     = 16;
	localparam int HEADER_BYTES   = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 64;

	typedef struct {
		logic             k;
		logic [31:0]      req;
		logic [31:0]      adr;
		logic [31:0]      sz;
		bit               typed;
		ffa_pkg::result_t want;
	} stim_row_t;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        in_valid      = 1'b0;
	logic        in_stall;
	logic        kind          = ffa_pkg::KIND_ALLOC;
	logic [31:0] request_size  = '0;
	logic [31:0] block_address = '0;
	logic [31:0] block_size    = '0;
	logic        out_valid;
	logic        out_stall     = 1'b0;
	logic [31:0] granted_address;
	logic [31:0] granted_size;
	logic [2:0]  status;
	logic        cfg_wr_en     = 1'b0;
	logic        cfg_index     = ffa_pkg::CFG_HEAP_BASE;
	logic [31:0] cfg_data      = '0;

	// shadow of the allocator state
	logic [31:0] shadow_addr [FREE_SLOTS];
	logic [31:0] shadow_size [FREE_SLOTS];
	int          shadow_count = 0;
	logic [31:0] shadow_brk   = '0;
	logic [31:0] cfg_limit    = '0;

	ffa_pkg::result_t grant_queue[$];
	ffa_pkg::entry_t  live_blocks[$];
	stim_row_t        stim_table[$];
	ffa_pkg::result_t head_grant;

	int fault_count  = 0;
	int stuck_cycles = 0;
	int stall_left   = 0;
	int rx_tick      = 0;
	bit rx_busy      = 1'b1;
	bit tx_busy      = 1'b1;
	bit full_rate    = 1'b0;

	first_fit_free_list_allocator_top #(
		.FREE_SLOTS(FREE_SLOTS),
		.HEADER_BYTES(HEADER_BYTES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.request_size(request_size),
		.block_address(block_address),
		.block_size(block_size),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.granted_address(granted_address),
		.granted_size(granted_size),
		.status(status),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic ffa_pkg::result_t allocate_or_free(input logic k,
			input logic [31:0] req, input logic [31:0] adr, input logic [31:0] sz);
		ffa_pkg::result_t r;
		logic [32:0]      rounded;
		logic [32:0]      reach;
		int               slot;
		int               j;
		r.addr   = '0;
		r.size   = '0;
		r.status = ffa_pkg::STAT_FREED;
		if (k == ffa_pkg::KIND_FREE) begin
			if (adr == '0)
				return r;
			if (shadow_count >= FREE_SLOTS) begin
				r.status = ffa_pkg::STAT_DROPPED;
				return r;
			end
			shadow_addr[shadow_count] = adr;
			shadow_size[shadow_count] = sz & ~32'h7;
			shadow_count++;
			return r;
		end
		rounded = ({1'b0, req} + 33'd7) & ~33'd7;
		r.status = ffa_pkg::STAT_NOMEM;
		if (rounded > {1'b0, ffa_pkg::MAX_REQUEST})
			return r;
		// newest entry first, taken whole, older order kept
		for (slot = shadow_count - 1; slot >= 0; slot--) begin
			if ({1'b0, shadow_size[slot]} >= rounded) begin
				r.addr   = shadow_addr[slot];
				r.size   = shadow_size[slot];
				r.status = ffa_pkg::STAT_REUSED;
				for (j = slot; j < shadow_count - 1; j++) begin
					shadow_addr[j] = shadow_addr[j + 1];
					shadow_size[j] = shadow_size[j + 1];
				end
				shadow_count--;
				return r;
			end
		end
		reach = {1'b0, shadow_brk} + rounded + HEADER_BYTES;
		if (reach > {1'b0, cfg_limit})
			return r;
		r.addr     = shadow_brk + HEADER_BYTES;
		r.size     = rounded[31:0];
		r.status   = ffa_pkg::STAT_GROWN;
		shadow_brk = reach[31:0];
		return r;
	endfunction

	// caller guarantees the block is idle
	task automatic set_heap(input logic [31:0] base, input logic [31:0] limit);
		cfg_wr_en <= 1'b1;
		cfg_index <= ffa_pkg::CFG_HEAP_BASE;
		cfg_data  <= base;
		@(posedge clk);
		cfg_index <= ffa_pkg::CFG_HEAP_LIMIT;
		cfg_data  <= limit;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		shadow_brk = base;
		cfg_limit  = limit;
	endtask

	task automatic send_item(input logic k, input logic [31:0] req, input logic [31:0] adr,
			input logic [31:0] sz, input bit typed, input ffa_pkg::result_t want);
		ffa_pkg::result_t got;
		ffa_pkg::entry_t  blk;
		if (!full_rate && tx_busy && $urandom_range(3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid      <= 1'b1;
		kind          <= k;
		request_size  <= req;
		block_address <= adr;
		block_size    <= sz;
		do
			@(posedge clk);
		while (in_stall);
		got = allocate_or_free(k, req, adr, sz);
		grant_queue.push_back(typed ? want : got);
		if (got.status == ffa_pkg::STAT_REUSED || got.status == ffa_pkg::STAT_GROWN) begin
			blk.addr = got.addr;
			blk.size = got.size;
			live_blocks.push_back(blk);
			if (live_blocks.size() > 48)
				void'(live_blocks.pop_front());
		end
	endtask

	task automatic random_item(input int free_pct);
		logic [31:0]     req;
		logic [31:0]     adr;
		logic [31:0]     sz;
		logic            k;
		ffa_pkg::entry_t pick;
		int              idx;
		int              sel;
		req = $urandom;
		adr = $urandom;
		sz  = $urandom;
		k   = ($urandom_range(99) < free_pct) ? ffa_pkg::KIND_FREE : ffa_pkg::KIND_ALLOC;
		sel = $urandom_range(19);
		if (k == ffa_pkg::KIND_FREE) begin
			if (sel == 0) begin
				adr = '0;
			end else if (sel > 3 && live_blocks.size() != 0) begin
				// hand back a block that was granted earlier
				idx  = $urandom_range(live_blocks.size() - 1);
				pick = live_blocks[idx];
				live_blocks.delete(idx);
				adr  = pick.addr;
				sz   = (sel == 4) ? (pick.size | ($urandom & 32'h7)) : pick.size;
			end
		end else begin
			if (sel == 0)
				req = 32'hFFFF_FFF0 | ($urandom & 32'hF);
			else if (sel == 1)
				req = '0;
			else if (sel > 3)
				req = $urandom_range(0, 160);
		end
		send_item(k, req, adr, sz, 1'b0, '0);
	endtask

	task automatic add_row(input logic k, input logic [31:0] req, input logic [31:0] adr,
			input logic [31:0] sz, input bit typed, input logic [31:0] want_addr,
			input logic [31:0] want_size, input ffa_pkg::status_t want_status);
		stim_row_t row;
		row.k           = k;
		row.req         = req;
		row.adr         = adr;
		row.sz          = sz;
		row.typed       = typed;
		row.want.addr   = want_addr;
		row.want.size   = want_size;
		row.want.status = want_status;
		stim_table.push_back(row);
	endtask

	task automatic run_phase(input logic [31:0] base, input logic [31:0] limit,
			input int free_pct, input int items);
		int n;
		in_valid <= 1'b0;
		// wait for the last result and for the table close-up to finish
		while (grant_queue.size() != 0 || in_stall)
			@(posedge clk);
		set_heap(base, limit);
		for (n = 0; n < items; n++) begin
			if (n % 40 == 0)
				tx_busy = $urandom_range(1);
			random_item(free_pct);
		end
	endtask

	// heap 0x1000..0x1040 for the directed rows
	initial begin
		add_row(ffa_pkg::KIND_ALLOC, 32'd0,         32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
			32'h1008, 32'd0, ffa_pkg::STAT_GROWN);
		add_row(ffa_pkg::KIND_ALLOC, 32'd1,         32'd0,         32'd0,         1,
			32'h1010, 32'd8, ffa_pkg::STAT_GROWN);
		add_row(ffa_pkg::KIND_ALLOC, 32'hFFFF_FFFF, 32'd0,         32'd0,         1,
			32'd0, 32'd0, ffa_pkg::STAT_NOMEM);
		add_row(ffa_pkg::KIND_ALLOC, 32'hFFFF_FFF9, 32'd0,         32'd0,         1,
			32'd0, 32'd0, ffa_pkg::STAT_NOMEM);
		// ends exactly on the limit
		add_row(ffa_pkg::KIND_ALLOC, 32'h20,        32'd0,         32'd0,         0,
			32'd0, 32'd0, ffa_pkg::STAT_FREED);
		add_row(ffa_pkg::KIND_ALLOC, 32'd0,         32'd0,         32'd0,         1,
			32'd0, 32'd0, ffa_pkg::STAT_NOMEM);
		add_row(ffa_pkg::KIND_FREE,  32'hFFFF_FFFF, 32'd0,         32'hFFFF_FFFF, 1,
			32'd0, 32'd0, ffa_pkg::STAT_FREED);
		add_row(ffa_pkg::KIND_FREE,  32'd0,         32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
			32'd0, 32'd0, ffa_pkg::STAT_FREED);
		add_row(ffa_pkg::KIND_FREE,  32'd0,         32'h1010,      32'h0F,        0,
			32'd0, 32'd0, ffa_pkg::STAT_FREED);
		add_row(ffa_pkg::KIND_FREE,  32'd0,         32'h1008,      32'd0,         0,
			32'd0, 32'd0, ffa_pkg::STAT_FREED);
		// skips two small entries, takes the oldest
		add_row(ffa_pkg::KIND_ALLOC, 32'hFFFF_FFF8, 32'd0,         32'd0,         1,
			32'hFFFF_FFFF, 32'hFFFF_FFF8, ffa_pkg::STAT_REUSED);
		add_row(ffa_pkg::KIND_ALLOC, 32'd0,         32'd0,         32'd0,         0,
			32'd0, 32'd0, ffa_pkg::STAT_FREED);
		// same block freed twice
		add_row(ffa_pkg::KIND_FREE,  32'd0,         32'h1010,      32'd8,         0,
			32'd0, 32'd0, ffa_pkg::STAT_FREED);
		add_row(ffa_pkg::KIND_FREE,  32'd0,         32'h1010,      32'd8,         0,
			32'd0, 32'd0, ffa_pkg::STAT_FREED);
		add_row(ffa_pkg::KIND_ALLOC, 32'd5,         32'd0,         32'd0,         0,
			32'd0, 32'd0, ffa_pkg::STAT_FREED);
		add_row(ffa_pkg::KIND_ALLOC, 32'd8,         32'd0,         32'd0,         0,
			32'd0, 32'd0, ffa_pkg::STAT_FREED);
		add_row(ffa_pkg::KIND_ALLOC, 32'd1,         32'd0,         32'd0,         0,
			32'd0, 32'd0, ffa_pkg::STAT_FREED);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		set_heap(32'h0000_1000, 32'h0000_1040);
		foreach (stim_table[i])
			send_item(stim_table[i].k, stim_table[i].req, stim_table[i].adr,
				stim_table[i].sz, stim_table[i].typed, stim_table[i].want);

		run_phase(32'h0000_1000, 32'h0001_0000, 50, 200);
		run_phase(32'h0000_0000, 32'hFFFF_FFFF, 40, 200);
		// mostly frees near the top of memory: table fills and drops
		run_phase(32'hFFFF_F000, 32'hFFFF_FFFF, 75, 200);
		// break already beyond the limit
		run_phase(32'h8000_0000, 32'h0000_0100, 30, 150);
		run_phase(32'h0000_0000, 32'h0000_0000, 50, 100);
		full_rate = 1'b1;
		run_phase(32'h5A5A_0000, 32'hA5A5_FFFF, 45, 300);

		in_valid <= 1'b0;
		while (grant_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		fault_count += grant_queue.size();
		if (fault_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// result side: check, then decide stall for the next cycle
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (grant_queue.size() == 0) begin
					fault_count++;
					if (fault_count <= 10)
						$display("unexpected item: addr %h size %h status %0d",
							granted_address, granted_size, status);
				end else begin
					head_grant = grant_queue.pop_front();
					if (granted_address !== head_grant.addr
							|| granted_size !== head_grant.size
							|| status !== head_grant.status) begin
						fault_count++;
						if (fault_count <= 10)
							$display({"mismatch: exp addr %h size %h status %0d,",
								" got addr %h size %h status %0d"},
								head_grant.addr, head_grant.size, head_grant.status,
								granted_address, granted_size, status);
					end
				end
			end
			if (stall_left != 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (!full_rate && rx_busy && $urandom_range(5) == 0) begin
				stall_left = $urandom_range(0, 15);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
			rx_tick++;
			if (rx_tick % 64 == 0)
				rx_busy = $urandom_range(1);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				stuck_cycles <= 0;
			end else if (stuck_cycles == WATCHDOG_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end else begin
				stuck_cycles <= stuck_cycles + 1;
			end
		end
	end

endmodule
